[src/ltt_pkg.sv]
`timescale 1ns / 1ps

package ltt_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 9;
  localparam int KEY_W       = 20;
  localparam int TICK_W      = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam idx_t IDX_LAST = idx_t'(MAX_ENTRIES - 1);

  localparam logic KIND_ENTER  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // slot store read request
  typedef struct packed {
    logic en;
    idx_t idx;
  } rd_req_t;

  // slot store write request; a write always marks the slot valid
  typedef struct packed {
    logic  en;
    idx_t  idx;
    key_t  key;
    tick_t tick;
  } wr_req_t;

  // registered read response
  typedef struct packed {
    logic  vld;
    idx_t  idx;
    logic  slot_valid;
    key_t  key;
    tick_t tick;
  } rd_rsp_t;

endpackage

[src/lru_tick_table.sv]
`timescale 1ns / 1ps

// Tick-stamped LRU table of up to MAX_ENTRIES keys. Every transaction on the
// input channel is handled by a scan over the slot memory, one slot per cycle
// through its single registered read port: the scan finds the key, the lowest
// free slot and the slot of the current eviction victim in one pass. A lookup
// or a plain refresh/insert then makes at most one write into the slot store
// and hands its result to the output register. When the oldest key must be
// recomputed (table just became full, the victim was refreshed, or an eviction
// was attempted) a second pass over the memory looks for the smallest tick,
// lowest slot winning ties, and the new victim is committed first. One
// transaction is in work at a time; in_stall stays high from
// acceptance until the result is written to the output register, and a new
// transaction may be taken while that result still waits on out_stall.
// The capacity register is taken only while the table is empty and is
// saturated at MAX_ENTRIES; with capacity zero every entry is rejected.
// No clearing pass is needed after reset: each slot has its own valid bit.

module lru_tick_table
  import ltt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [TICK_W-1:0] in_tick,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_status,
  output logic             out_found,
  output logic [TICK_W-1:0] out_stored_tick,
  output logic [KEY_W-1:0]  out_oldest_key,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_capacity
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,   // match / free / victim pass
    ST_ACT,    // at most one write into the slot store
    ST_MIN,    // smallest-tick pass
    ST_FIN,    // commit new victim
    ST_DONE    // hand result to output register
  } state_t;

  state_t state_r;

  // captured transaction
  logic  kind_r;
  key_t  key_r;
  tick_t tick_r;

  // persistent state
  cnt_t  cap_r;
  cnt_t  count_r;
  key_t  victim_key_r;

  // scan sequencer
  idx_t  issue_idx_r;
  logic  issuing_r;

  // match pass results
  logic  hit_r;
  idx_t  hit_idx_r;
  tick_t hit_tick_r;
  logic  free_r;
  idx_t  free_idx_r;
  logic  vic_r;
  idx_t  vic_idx_r;

  // min pass results
  logic  any_r;
  tick_t best_tick_r;
  key_t  best_key_r;

  // pending result
  logic  res_status_r;
  tick_t res_stored_r;

  // output register
  logic  out_valid_r;
  logic  out_status_r;
  logic  out_found_r;
  tick_t out_stored_r;
  key_t  out_oldest_r;

  rd_req_t rd;
  wr_req_t wr;
  rd_rsp_t rsp;

  ltt_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd),
    .wr    (wr),
    .rsp   (rsp)
  );

  // shared compare unit: one key compare, one victim compare, one tick compare
  logic rsp_last;
  logic key_eq;
  logic vic_eq;
  logic tick_lt;

  assign rsp_last = rsp.vld && (rsp.idx == IDX_LAST);
  assign key_eq   = rsp.vld && rsp.slot_valid && (rsp.key == key_r);
  assign vic_eq   = rsp.vld && rsp.slot_valid && (rsp.key == victim_key_r);
  assign tick_lt  = rsp.vld && rsp.slot_valid && (!any_r || (rsp.tick < best_tick_r));

  // capacity saturation
  cnt_t cap_sat;
  assign cap_sat = (32'(cfg_capacity) > 32'(MAX_ENTRIES)) ? cnt_t'(MAX_ENTRIES)
                                                          : cnt_t'(cfg_capacity);

  // action decode, used in ST_ACT
  logic act_wr;
  idx_t act_idx;
  logic act_status;
  logic act_inc;
  logic act_to_min;
  cnt_t count_inc;

  assign count_inc = count_r + cnt_t'(1);

  always_comb begin
    act_wr     = 1'b0;
    act_idx    = hit_idx_r;
    act_status = STATUS_DONE;
    act_inc    = 1'b0;
    act_to_min = 1'b0;
    if (kind_r == KIND_LOOKUP) begin
      act_wr = 1'b0;
    end else if (count_r < cap_r) begin
      if (hit_r) begin
        act_wr = 1'b1;
      end else if (free_r) begin
        act_wr     = 1'b1;
        act_idx    = free_idx_r;
        act_inc    = 1'b1;
        act_to_min = (count_inc == cap_r);
      end else begin
        act_status = STATUS_REJECTED;
      end
    end else begin
      if (hit_r) begin
        act_wr     = 1'b1;
        act_to_min = (key_r == victim_key_r);
      end else begin
        if (vic_r) begin
          act_wr  = 1'b1;
          act_idx = vic_idx_r;
        end else begin
          act_status = STATUS_REJECTED;
        end
        act_to_min = 1'b1;
      end
    end
  end

  always_comb begin
    rd.en    = issuing_r;
    rd.idx   = issue_idx_r;
    wr.en    = (state_r == ST_ACT) && act_wr;
    wr.idx   = act_idx;
    wr.key   = key_r;
    wr.tick  = tick_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= '0;
      count_r      <= '0;
      victim_key_r <= '0;
      issuing_r    <= 1'b0;
      issue_idx_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // capacity only changes while the table is empty
      if (cfg_wr_en && (count_r == '0)) begin
        cap_r <= cap_sat;
      end

      // ST_DONE reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // address sequencer shared by both passes
      if (issuing_r) begin
        issue_idx_r <= issue_idx_r + idx_t'(1);
        if (issue_idx_r == IDX_LAST) begin
          issuing_r <= 1'b0;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r      <= in_kind;
            key_r       <= in_key;
            tick_r      <= in_tick;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            vic_r       <= 1'b0;
            issue_idx_r <= '0;
            issuing_r   <= 1'b1;
            state_r     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (key_eq && !hit_r) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= rsp.idx;
            hit_tick_r <= rsp.tick;
          end
          if (rsp.vld && !rsp.slot_valid && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= rsp.idx;
          end
          if (vic_eq && !vic_r) begin
            vic_r     <= 1'b1;
            vic_idx_r <= rsp.idx;
          end
          if (rsp_last) begin
            state_r <= ST_ACT;
          end
        end

        ST_ACT: begin
          res_status_r <= act_status;
          res_stored_r <= (kind_r == KIND_LOOKUP && hit_r) ? hit_tick_r : '0;
          if (act_inc) begin
            count_r <= count_inc;
          end
          if (act_to_min) begin
            any_r       <= 1'b0;
            best_key_r  <= '0;
            issue_idx_r <= '0;
            issuing_r   <= 1'b1;
            state_r     <= ST_MIN;
          end else begin
            state_r <= ST_DONE;
          end
        end

        ST_MIN: begin
          if (tick_lt) begin
            any_r       <= 1'b1;
            best_tick_r <= rsp.tick;
            best_key_r  <= rsp.key;
          end
          if (rsp_last) begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          victim_key_r <= best_key_r;
          state_r      <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_found_r  <= hit_r;
            out_stored_r <= res_stored_r;
            out_oldest_r <= victim_key_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_stored_tick = out_stored_r;
  assign out_oldest_key  = out_oldest_r;

endmodule

[src/ltt_slots.sv]
`timescale 1ns / 1ps

module ltt_slots
  import ltt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  rd_req_t rd,
  input  wr_req_t wr,
  output rd_rsp_t rsp
);

  key_t  key_mem  [MAX_ENTRIES];
  tick_t tick_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;

  rd_rsp_t rsp_r;

  // key/tick storage: no reset, only reached through a valid bit
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.idx]  <= wr.key;
      tick_mem[wr.idx] <= wr.tick;
    end
    rsp_r.idx        <= rd.idx;
    rsp_r.key        <= key_mem[rd.idx];
    rsp_r.tick       <= tick_mem[rd.idx];
    rsp_r.slot_valid <= valid_r[rd.idx];
    if (!rst_n) begin
      valid_r   <= '0;
      rsp_r.vld <= 1'b0;
    end else begin
      rsp_r.vld <= rd.en;
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

[src/ltt_checker.sv]
`timescale 1ns / 1ps

module ltt_checker
  import ltt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_status,
  input logic             out_found,
  input logic [TICK_W-1:0] out_stored_tick,
  input logic [KEY_W-1:0]  out_oldest_key
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_stored_tick) && $stable(out_oldest_key))
    else $error("result changed while stalled");

  // an accepted transaction keeps the block busy for the scan
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again during scan");

  // a new result only follows a transaction in work
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without transaction");

  // a rejection only happens for a key that was absent
  a_reject_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_REJECTED) |-> !out_found)
    else $error("rejected transaction reports key present");

endmodule

bind lru_tick_table ltt_checker u_ltt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_stored_tick (out_stored_tick),
  .out_oldest_key  (out_oldest_key)
);
